### hw/rtl/kts_pkg.sv
// ----------------------------------------------------------------------------
// kts_pkg
// Shared types, constants and saturation helpers for the trajectory smoother.
// ----------------------------------------------------------------------------
package kts_pkg;

    localparam int CFG_IDX_W  = 2;
    localparam int DIV_STEPS  = 25;          // quotient bits, gain is Q1.24
    localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

    localparam logic [CFG_IDX_W-1:0] CFG_PROCESS_NOISE     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MEASUREMENT_NOISE = 2'd1;

    localparam logic [31:0] Q_RESET   = 32'd67109;
    localparam logic [31:0] R_RESET   = 32'd8388608;
    localparam logic [31:0] P_RESET   = 32'h0100_0000;   // 1.0 in Q8.24
    localparam logic [24:0] ONE_Q24   = 25'h100_0000;
    localparam logic [31:0] U32_MAX   = 32'hFFFF_FFFF;

    typedef struct packed {
        logic               motion_valid;
        logic signed [31:0] shift_x;
        logic signed [31:0] shift_y;
        logic signed [31:0] rotation;
    } t_in_item;

    typedef struct packed {
        logic               correction_valid;
        logic signed [31:0] corr_x;
        logic signed [31:0] corr_y;
        logic signed [31:0] corr_rotation;
    } t_out_item;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_status;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PRED,
        ST_DSTART,
        ST_DIV,
        ST_SUM,
        ST_DIFF,
        ST_ABS,
        ST_MHI,
        ST_MLO,
        ST_ACC,
        ST_UPD,
        ST_CORR,
        ST_COV,
        ST_COVW,
        ST_OUT
    } t_state;

    function automatic logic signed [47:0] sat48(input logic signed [48:0] v);
        logic signed [47:0] res;
        if (v[48] != v[47]) begin
            res = v[48] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};
        end else begin
            res = v[47:0];
        end
        return res;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [48:0] v);
        logic signed [31:0] res;
        if (!v[48] && (|v[47:31])) begin
            res = {1'b0, {31{1'b1}}};
        end else if (v[48] && !(&v[47:31])) begin
            res = {1'b1, 31'd0};
        end else begin
            res = v[31:0];
        end
        return res;
    endfunction

endpackage

### hw/rtl/kts_div.sv
// ----------------------------------------------------------------------------
// kts_div
// Serial restoring divider for the Kalman gain: quot = floor(num * 2^24 / den),
// one quotient bit per cycle. Zero divisor returns a gain of one.
// ----------------------------------------------------------------------------
module kts_div (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [31:0]           i_num,
    input  logic [32:0]           i_den,
    output kts_pkg::t_div_status  o_status,
    output logic [24:0]           o_quot
);
    import kts_pkg::*;

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [33:0]          r_rem;
    logic [32:0]          r_den;
    logic [24:0]          r_quot;

    logic                 ge;
    logic [33:0]          n_rem;

    // num <= den always, so the first remainder already fits below 2*den
    assign ge    = (r_rem >= {1'b0, r_den});
    assign n_rem = ge ? (r_rem - {1'b0, r_den}) : r_rem;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_cnt <= '0;
                if (i_den == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_busy <= 1'b1;
                end
            end else if (r_busy) begin
                if (r_cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= {2'b00, i_num};
            r_den  <= i_den;
            r_quot <= (i_den == '0) ? ONE_Q24 : '0;
        end else if (r_busy) begin
            r_rem  <= {n_rem[32:0], 1'b0};
            r_quot <= {r_quot[23:0], ge};
        end
    end

    assign o_status.busy = r_busy;
    assign o_status.done = r_done;
    assign o_quot        = r_quot;

endmodule

### hw/rtl/kts_mul.sv
// ----------------------------------------------------------------------------
// kts_mul
// Shared 25x32 unsigned multiplier with a registered product. Used for the
// gain scaling of each channel and for the covariance update.
// ----------------------------------------------------------------------------
module kts_mul (
    input  logic        i_clk,
    input  logic [24:0] i_a,
    input  logic [31:0] i_b,
    output logic [56:0] o_prod
);
    import kts_pkg::*;

    logic [56:0] r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= {32'd0, i_a} * {25'd0, i_b};
    end

    assign o_prod = r_prod;

endmodule

### hw/rtl/motion_trajectory_kalman_smoother.sv
// ----------------------------------------------------------------------------
// motion_trajectory_kalman_smoother
// Scalar Kalman smoother over the accumulated x, y and angle trajectory.
//
// Input channel: one beat per frame (motion_valid, shift_x, shift_y, rotation,
// Q16.16). Output channel: one beat per input beat with the correction
// (estimate minus accumulated trajectory, saturated to 32 bits), or all zeros
// with correction_valid low for an invalid frame or during the first frame.
// Config channel: index 0 writes q, index 1 writes r (Q8.24); other indexes
// are ignored. Writes are always taken and must land only while idle.
//
// A valid frame shows its result once the gain divider and the multiplier
// passes are done (the divider answers at once when predicted covariance
// plus r is zero); an invalid frame shows it in the cycle after its input
// beat. One item is in flight at a time. The run time is set by the 25-step
// serial gain divider and by three passes over the shared multiplier (two
// partial products per channel) plus the covariance product. A stalled
// receiver simply holds the result; no new beat is taken until it drains.
// Reset clears estimates and sums, sets covariance to 1.0, restores q and
// r, and restarts the first-frame warm-up.
// ----------------------------------------------------------------------------
module motion_trajectory_kalman_smoother (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  kts_pkg::t_in_item              i_in_data,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output kts_pkg::t_out_item             o_out_data,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [kts_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [31:0]                    i_cfg_data
);
    import kts_pkg::*;

    t_state              r_state;
    t_state              n_state;

    logic [31:0]         r_q;
    logic [31:0]         r_r;
    logic [1:0]          r_frames;
    logic                r_emit;
    logic [1:0]          r_ch;
    logic signed [47:0]  r_est [3];
    logic signed [47:0]  r_sum [3];
    logic [31:0]         r_p;

    t_in_item            r_in;
    t_out_item           r_out;
    logic [31:0]         r_pp;
    logic [24:0]         r_k;
    logic signed [48:0]  r_d;
    logic                r_neg;
    logic [47:0]         r_mag;
    logic [47:0]         r_acc;
    logic signed [31:0]  r_corr [3];

    logic                in_fire;
    logic                div_start;
    t_div_status         div_status;
    logic [24:0]         div_quot;
    logic [32:0]         div_den;
    logic [24:0]         mul_a;
    logic [31:0]         mul_b;
    logic [56:0]         mul_prod;
    logic [32:0]         pred_sum;
    logic signed [31:0]  motion;
    logic [1:0]          frames_inc;

    kts_div u_div (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (div_start),
        .i_num    (r_pp),
        .i_den    (div_den),
        .o_status (div_status),
        .o_quot   (div_quot)
    );

    kts_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (mul_a),
        .i_b    (mul_b),
        .o_prod (mul_prod)
    );

    assign in_fire    = i_in_valid && o_in_ready;
    assign div_den    = {1'b0, r_pp} + {1'b0, r_r};
    assign pred_sum   = {1'b0, r_p} + {1'b0, r_q};
    assign frames_inc = (r_frames < 2'd2) ? r_frames + 2'd1 : r_frames;

    always_comb begin
        case (r_ch)
            2'd0:    motion = r_in.shift_x;
            2'd1:    motion = r_in.shift_y;
            default: motion = r_in.rotation;
        endcase
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (in_fire) begin
                    n_state = i_in_data.motion_valid ? ST_PRED : ST_OUT;
                end
            end
            ST_PRED:   n_state = ST_DSTART;
            ST_DSTART: n_state = ST_DIV;
            ST_DIV: begin
                if (div_status.done) begin
                    n_state = ST_SUM;
                end
            end
            ST_SUM:  n_state = ST_DIFF;
            ST_DIFF: n_state = ST_ABS;
            ST_ABS:  n_state = ST_MHI;
            ST_MHI:  n_state = ST_MLO;
            ST_MLO:  n_state = ST_ACC;
            ST_ACC:  n_state = ST_UPD;
            ST_UPD:  n_state = ST_CORR;
            ST_CORR: n_state = (r_ch == 2'd2) ? ST_COV : ST_SUM;
            ST_COV:  n_state = ST_COVW;
            ST_COVW: n_state = ST_OUT;
            ST_OUT: begin
                if (i_out_ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        div_start   = 1'b0;
        mul_a       = r_k;
        mul_b       = '0;
        case (r_state)
            ST_IDLE:   o_in_ready  = 1'b1;
            ST_DSTART: div_start   = 1'b1;
            ST_MHI:    mul_b       = {8'd0, r_mag[47:24]};
            ST_MLO:    mul_b       = {8'd0, r_mag[23:0]};
            ST_COV: begin
                mul_a = ONE_Q24 - r_k;
                mul_b = r_pp;
            end
            ST_OUT:    o_out_valid = 1'b1;
            default: begin
            end
        endcase
    end

    assign o_cfg_ready = 1'b1;
    assign o_out_data  = r_out;

    // control and filter state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_q      <= Q_RESET;
            r_r      <= R_RESET;
            r_frames <= 2'd0;
            r_emit   <= 1'b0;
            r_ch     <= 2'd0;
            r_p      <= P_RESET;
            for (int i = 0; i < 3; i++) begin
                r_est[i] <= '0;
                r_sum[i] <= '0;
            end
        end else begin
            r_state <= n_state;
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == CFG_PROCESS_NOISE) begin
                    r_q <= i_cfg_data;
                end else if (i_cfg_index == CFG_MEASUREMENT_NOISE) begin
                    r_r <= i_cfg_data;
                end
            end
            case (r_state)
                ST_IDLE: begin
                    if (in_fire) begin
                        r_frames <= frames_inc;
                        r_emit   <= i_in_data.motion_valid && (frames_inc == 2'd2);
                        r_ch     <= 2'd0;
                    end
                end
                ST_SUM: begin
                    r_sum[r_ch] <= sat48({r_sum[r_ch][47], r_sum[r_ch]}
                                         + {{17{motion[31]}}, motion});
                end
                ST_UPD: begin
                    // step never passes the sum, so no saturation needed here
                    r_est[r_ch] <= r_neg ? (r_est[r_ch] - $signed(r_acc))
                                         : (r_est[r_ch] + $signed(r_acc));
                end
                ST_CORR: begin
                    if (r_ch != 2'd2) begin
                        r_ch <= r_ch + 2'd1;
                    end
                end
                ST_COVW: r_p <= mul_prod[55:24];
                default: begin
                end
            endcase
        end
    end

    // datapath payload
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                if (in_fire) begin
                    r_in  <= i_in_data;
                    r_out <= '0;
                end
            end
            ST_PRED: r_pp <= pred_sum[32] ? U32_MAX : pred_sum[31:0];
            ST_DIV: begin
                if (div_status.done) begin
                    r_k <= div_quot;
                end
            end
            ST_DIFF: r_d <= {r_sum[r_ch][47], r_sum[r_ch]} - {r_est[r_ch][47], r_est[r_ch]};
            ST_ABS: begin
                r_neg <= r_d[48];
                r_mag <= r_d[48] ? 48'(-r_d) : r_d[47:0];
            end
            ST_MLO:  r_acc <= mul_prod[47:0];
            ST_ACC:  r_acc <= r_acc + {23'd0, mul_prod[48:24]};
            ST_CORR: begin
                r_corr[r_ch] <= sat32({r_est[r_ch][47], r_est[r_ch]}
                                      - {r_sum[r_ch][47], r_sum[r_ch]});
            end
            ST_COVW: begin
                r_out.correction_valid <= r_emit;
                r_out.corr_x           <= r_emit ? r_corr[0] : '0;
                r_out.corr_y           <= r_emit ? r_corr[1] : '0;
                r_out.corr_rotation    <= r_emit ? r_corr[2] : '0;
            end
            default: begin
            end
        endcase
    end

endmodule

### hw/rtl/kts_chk.sv
// ----------------------------------------------------------------------------
// kts_chk
// Port-level checks for the trajectory smoother, bound to the top level.
// ----------------------------------------------------------------------------
module kts_chk (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    input  logic                           o_in_ready,
    input  kts_pkg::t_in_item              i_in_data,
    input  logic                           o_out_valid,
    input  logic                           i_out_ready,
    input  kts_pkg::t_out_item             o_out_data,
    input  logic                           i_cfg_valid,
    input  logic                           o_cfg_ready,
    input  logic [kts_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [31:0]                    i_cfg_data
);
    import kts_pkg::*;

    // a result beat waits for the receiver
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> o_out_valid)
        else $error("result beat dropped before it was taken");

    // one item in flight: never ready while a result is pending
    a_one_inflight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> !o_out_valid)
        else $error("input ready while a result is pending");

    a_busy_after_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("second beat taken while an item is in flight");

    // invalid frame gets its empty result straight away
    a_invalid_fast: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && !i_in_data.motion_valid) |=> o_out_valid)
        else $error("invalid frame result late");

    a_zero_when_invalid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_data.correction_valid) |->
        (o_out_data.corr_x == '0 && o_out_data.corr_y == '0
         && o_out_data.corr_rotation == '0))
        else $error("nonzero correction with correction_valid low");

endmodule

bind motion_trajectory_kalman_smoother kts_chk u_kts_chk (.*);
